>>> rtl/espp_pkg.sv
package espp_pkg;

    // Field widths of the streaming payload.
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned DIR_W    = 2;
    localparam int unsigned DUTY_W   = 14;
    localparam int unsigned IN_W     = 48;
    localparam int unsigned OUT_W    = 48;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TICK_W     = 10;
    localparam int unsigned CPR_W      = 16;
    localparam int unsigned GAIN_W     = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TICK_MS        = 3'd0,
        CFG_INVERT_COUNT   = 3'd1,
        CFG_COUNTS_PER_REV = 3'd2,
        CFG_GAIN_P         = 3'd3,
        CFG_GAIN_I         = 3'd4,
        CFG_GAIN_D         = 3'd5
    } cfg_addr_t;

    // Direction codes of the drive.
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BWD  = 2'd2;

    // Operation codes carried on the input tuser.
    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_CLEAR_POS = 1'b1;

    // Fixed scaling of the loop.
    localparam int unsigned GAIN_FRAC_BITS = 8;
    localparam int unsigned MAX_DUTY       = 10000;
    localparam int unsigned SPEED_SCALE    = 60000;
    localparam int unsigned DERIV_SCALE    = 1000;

    // Datapath widths of the serial arithmetic.
    localparam int unsigned ACC_W  = 48;
    localparam int unsigned MULB_W = 16;
    localparam int unsigned QUO_W  = 17;
    localparam int unsigned DEN_W  = TICK_W + CPR_W;
    localparam int unsigned KQ_W   = 10;
    localparam int unsigned DERV_W = 27;
    localparam int unsigned CNT_W  = 5;

endpackage

>>> rtl/encoder_speed_pid_pwm.sv
// Channel   Signals                      Contents (lowest bits first)
// s_axis    tvalid tready tdata tuser    tdata: counter_value, target_speed; tuser: op
// m_axis    tvalid tready tdata tuser    tdata: measured_speed, control_value, direction,
//                                        duty; tuser: clear_counter
// cfg       cfg_we cfg_addr cfg_wdata    register index 0..5, 16-bit data, no read-back
//
// A control tick runs S_DEN, S_NUM, S_SCHK, S_SDIV, S_SPD, S_ERR, S_KDIV, S_DER, S_MP,
// S_MI, S_MD, S_SCL and S_OUT, skipping S_SDIV when the speed saturates early; a
// clear-position request goes straight to S_OUT. A new request is taken only in S_IDLE.
// The work is done by one shared bit-serial multiply-accumulate unit (six products)
// and one restoring divider that produces one quotient bit per cycle.
// Reset clears the loop state and loads the register defaults; no clearing pass.
// A result waits in the output register while the next request is already taken.
module encoder_speed_pid_pwm
#(
    parameter int unsigned GAIN_FRAC_BITS = espp_pkg::GAIN_FRAC_BITS,
    parameter int unsigned MAX_DUTY       = espp_pkg::MAX_DUTY
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // counter_value [31:0], target_speed [47:32]
    input  logic [espp_pkg::IN_W-1:0]         s_axis_tdata,
    // op [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // measured_speed [15:0], control_value [31:16], direction [33:32], duty [47:34]
    output logic [espp_pkg::OUT_W-1:0]        m_axis_tdata,
    // clear_counter [0]
    output logic                              m_axis_tuser,
    input  logic                              cfg_we,
    input  logic [espp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [espp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import espp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DEN, S_NUM, S_SCHK, S_SDIV, S_SPD, S_ERR,
        S_KDIV, S_DER, S_MP, S_MI, S_MD, S_SCL, S_OUT
    } state_t;

    localparam logic signed [ACC_W-1:0] ROUND_ADD = (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);
    localparam logic signed [17:0] DUTY_MAX_S = 18'(MAX_DUTY);

    // Configuration registers.
    logic [TICK_W-1:0]        tick_ms_reg;
    logic                     invert_reg;
    logic [CPR_W-1:0]         cpr_reg;
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;

    // Loop state.
    state_t                    state_reg;
    logic [COUNT_W-1:0]        last_position_reg;
    logic signed [31:0]        error_sum_reg;
    logic signed [SPEED_W-1:0] prev_error_reg;

    // Per-request working registers.
    logic [COUNT_W-1:0]        mag_reg;
    logic                      neg_reg;
    logic signed [SPEED_W-1:0] target_reg;
    logic [DEN_W-1:0]          den_reg;
    logic                      ovf_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [SPEED_W-1:0] err_reg;
    logic signed [SPEED_W:0]   derr_reg;
    logic signed [DERV_W-1:0]  deriv_reg;
    logic signed [SPEED_W-1:0] ctrl_reg;
    logic                      clr_reg;

    // Serial multiply-accumulate and divider registers.
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   mul_a_reg;
    logic [MULB_W-1:0]         mul_b_reg;
    logic                      mul_sgn_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [ACC_W-1:0]          rem_reg;
    logic [ACC_W-1:0]          dsh_reg;
    logic [QUO_W-1:0]          quo_reg;

    // Output register.
    logic                      m_valid_reg;
    logic [OUT_W-1:0]          m_data_reg;
    logic                      m_user_reg;

    // Effective period and resolution, with zero read as one.
    logic [TICK_W-1:0] tick_eff;
    logic [CPR_W-1:0]  cpr_eff;
    assign tick_eff = (tick_ms_reg == '0) ? TICK_W'(1) : tick_ms_reg;
    assign cpr_eff  = (cpr_reg == '0) ? CPR_W'(1) : cpr_reg;

    // Position change on request.
    logic [COUNT_W-1:0] in_count;
    logic [COUNT_W-1:0] pos_next;
    logic [COUNT_W-1:0] delta_next;
    assign in_count   = s_axis_tdata[COUNT_W-1:0];
    assign pos_next   = invert_reg ? (COUNT_W'(0) - in_count) : in_count;
    assign delta_next = pos_next - last_position_reg;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    // One bit of the multiplier per cycle; the top bit of a signed multiplier subtracts.
    logic                    mul_neg;
    logic signed [ACC_W-1:0] mul_term;
    logic signed [ACC_W-1:0] mul_sum;
    logic                    cnt_last;
    assign cnt_last = (cnt_reg == '0);
    assign mul_neg  = mul_sgn_reg && cnt_last;
    assign mul_term = !mul_b_reg[0] ? '0 : (mul_neg ? -mul_a_reg : mul_a_reg);
    assign mul_sum  = acc_reg + mul_term;

    // One quotient bit per cycle of the restoring divider.
    logic             div_ge;
    logic [ACC_W-1:0] div_rem;
    logic [QUO_W-1:0] div_quo;
    assign div_ge  = (rem_reg >= dsh_reg);
    assign div_rem = div_ge ? (rem_reg - dsh_reg) : rem_reg;
    assign div_quo = {quo_reg[QUO_W-2:0], div_ge};

    // Early saturation test of the speed quotient.
    logic speed_ovf;
    assign speed_ovf = (acc_reg >= (ACC_W'(den_reg) << QUO_W));

    // Truncated, saturated speed from the quotient magnitude.
    logic signed [SPEED_W-1:0] speed_next;
    always_comb
    begin
        if (neg_reg)
        begin
            if (ovf_reg || quo_reg >= QUO_W'(32768))
                speed_next = 16'sh8000;
            else
                speed_next = -$signed(quo_reg[SPEED_W-1:0]);
        end
        else
        begin
            if (ovf_reg || quo_reg > QUO_W'(32767))
                speed_next = 16'sh7FFF;
            else
                speed_next = $signed(quo_reg[SPEED_W-1:0]);
        end
    end

    // Error, running sum and error difference.
    logic signed [SPEED_W:0]   err_wide;
    logic signed [SPEED_W-1:0] err_next;
    logic signed [32:0]        sum_wide;
    logic signed [31:0]        error_sum_next;
    always_comb
    begin
        err_wide = 17'(target_reg) - 17'(speed_reg);
        if (err_wide > 17'sd32767)
            err_next = 16'sh7FFF;
        else if (err_wide < -17'sd32768)
            err_next = 16'sh8000;
        else
            err_next = err_wide[SPEED_W-1:0];
        sum_wide = 33'(error_sum_reg) + 33'(err_next);
        if (sum_wide[32] != sum_wide[31])
            error_sum_next = sum_wide[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            error_sum_next = sum_wide[31:0];
    end

    // Gain scaling truncated toward zero, then saturated.
    logic signed [ACC_W-1:0]   pid_round;
    logic signed [ACC_W-1:0]   pid_shift;
    logic signed [SPEED_W-1:0] ctrl_next;
    always_comb
    begin
        pid_round = acc_reg[ACC_W-1] ? (acc_reg + ROUND_ADD) : acc_reg;
        pid_shift = pid_round >>> GAIN_FRAC_BITS;
        if (pid_shift > 48'sd32767)
            ctrl_next = 16'sh7FFF;
        else if (pid_shift < -48'sd32768)
            ctrl_next = 16'sh8000;
        else
            ctrl_next = pid_shift[SPEED_W-1:0];
    end

    // Drive clamp and split into direction and duty.
    logic signed [17:0] ctrl_ext;
    logic signed [17:0] drive;
    logic [DIR_W-1:0]   dir_next;
    logic [DUTY_W-1:0]  duty_next;
    always_comb
    begin
        ctrl_ext = 18'(ctrl_reg);
        if (ctrl_ext > DUTY_MAX_S)
            drive = DUTY_MAX_S;
        else if (ctrl_ext < -DUTY_MAX_S)
            drive = -DUTY_MAX_S;
        else
            drive = ctrl_ext;
        if (drive < 0)
        begin
            dir_next  = DIR_BWD;
            duty_next = DUTY_W'(-drive);
        end
        else if (drive > 0)
        begin
            dir_next  = DIR_FWD;
            duty_next = DUTY_W'(drive);
        end
        else
        begin
            dir_next  = DIR_STOP;
            duty_next = '0;
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_axis_tready;

    // Sequencer, loop state, configuration and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            tick_ms_reg       <= TICK_W'(10);
            invert_reg        <= 1'b0;
            cpr_reg           <= CPR_W'(1);
            gain_p_reg        <= 16'sd256;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
            last_position_reg <= '0;
            error_sum_reg     <= '0;
            prev_error_reg    <= '0;
            m_valid_reg       <= 1'b0;
            m_data_reg        <= '0;
            m_user_reg        <= 1'b0;
            mag_reg           <= '0;
            neg_reg           <= 1'b0;
            target_reg        <= '0;
            den_reg           <= '0;
            ovf_reg           <= 1'b0;
            speed_reg         <= '0;
            err_reg           <= '0;
            derr_reg          <= '0;
            deriv_reg         <= '0;
            ctrl_reg          <= '0;
            clr_reg           <= 1'b0;
            acc_reg           <= '0;
            mul_a_reg         <= '0;
            mul_b_reg         <= '0;
            mul_sgn_reg       <= 1'b0;
            cnt_reg           <= '0;
            rem_reg           <= '0;
            dsh_reg           <= '0;
            quo_reg           <= '0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_TICK_MS:        tick_ms_reg <= cfg_wdata[TICK_W-1:0];
                    CFG_INVERT_COUNT:   invert_reg  <= cfg_wdata[0];
                    CFG_COUNTS_PER_REV: cpr_reg     <= cfg_wdata[CPR_W-1:0];
                    CFG_GAIN_P:         gain_p_reg  <= $signed(cfg_wdata[GAIN_W-1:0]);
                    CFG_GAIN_I:         gain_i_reg  <= $signed(cfg_wdata[GAIN_W-1:0]);
                    CFG_GAIN_D:         gain_d_reg  <= $signed(cfg_wdata[GAIN_W-1:0]);
                    default:            ;
                endcase
            end

            // The output drains independently of the sequencer.
            if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;

            // Shared serial units advance every cycle; each state uses what it needs.
            mul_a_reg <= mul_a_reg <<< 1;
            mul_b_reg <= mul_b_reg >> 1;
            cnt_reg   <= cnt_reg - CNT_W'(1);
            rem_reg   <= div_rem;
            dsh_reg   <= dsh_reg >> 1;
            quo_reg   <= div_quo;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_axis_tuser == OP_CLEAR_POS)
                        begin
                            last_position_reg <= '0;
                            speed_reg         <= '0;
                            ctrl_reg          <= '0;
                            clr_reg           <= 1'b1;
                            state_reg         <= S_OUT;
                        end
                        else
                        begin
                            last_position_reg <= pos_next;
                            neg_reg           <= delta_next[COUNT_W-1];
                            mag_reg           <= delta_next[COUNT_W-1] ?
                                                 (COUNT_W'(0) - delta_next) : delta_next;
                            target_reg        <= $signed(s_axis_tdata[IN_W-1:COUNT_W]);
                            clr_reg           <= 1'b0;
                            acc_reg           <= '0;
                            mul_a_reg         <= ACC_W'(cpr_eff);
                            mul_b_reg         <= MULB_W'(tick_eff);
                            mul_sgn_reg       <= 1'b0;
                            cnt_reg           <= CNT_W'(TICK_W - 1);
                            state_reg         <= S_DEN;
                        end
                    end
                end
                S_DEN:
                begin
                    acc_reg <= mul_sum;
                    if (cnt_last)
                    begin
                        den_reg     <= mul_sum[DEN_W-1:0];
                        acc_reg     <= '0;
                        mul_a_reg   <= ACC_W'(mag_reg);
                        mul_b_reg   <= MULB_W'(SPEED_SCALE);
                        mul_sgn_reg <= 1'b0;
                        cnt_reg     <= CNT_W'(MULB_W - 1);
                        state_reg   <= S_NUM;
                    end
                end
                S_NUM:
                begin
                    acc_reg <= mul_sum;
                    if (cnt_last)
                        state_reg <= S_SCHK;
                end
                S_SCHK:
                begin
                    ovf_reg   <= speed_ovf;
                    rem_reg   <= acc_reg;
                    dsh_reg   <= ACC_W'(den_reg) << (QUO_W - 1);
                    quo_reg   <= '0;
                    cnt_reg   <= CNT_W'(QUO_W - 1);
                    state_reg <= speed_ovf ? S_SPD : S_SDIV;
                end
                S_SDIV:
                begin
                    if (cnt_last)
                        state_reg <= S_SPD;
                end
                S_SPD:
                begin
                    speed_reg <= speed_next;
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    err_reg        <= err_next;
                    error_sum_reg  <= error_sum_next;
                    derr_reg       <= 17'(err_next) - 17'(prev_error_reg);
                    prev_error_reg <= err_next;
                    rem_reg        <= ACC_W'(DERIV_SCALE);
                    dsh_reg        <= ACC_W'(tick_eff) << (KQ_W - 1);
                    quo_reg        <= '0;
                    cnt_reg        <= CNT_W'(KQ_W - 1);
                    state_reg      <= S_KDIV;
                end
                S_KDIV:
                begin
                    if (cnt_last)
                    begin
                        acc_reg     <= '0;
                        mul_a_reg   <= ACC_W'(derr_reg);
                        mul_b_reg   <= MULB_W'(div_quo[KQ_W-1:0]);
                        mul_sgn_reg <= 1'b0;
                        cnt_reg     <= CNT_W'(KQ_W - 1);
                        state_reg   <= S_DER;
                    end
                end
                S_DER:
                begin
                    acc_reg <= mul_sum;
                    if (cnt_last)
                    begin
                        deriv_reg   <= mul_sum[DERV_W-1:0];
                        acc_reg     <= '0;
                        mul_a_reg   <= ACC_W'(err_reg);
                        mul_b_reg   <= gain_p_reg;
                        mul_sgn_reg <= 1'b1;
                        cnt_reg     <= CNT_W'(MULB_W - 1);
                        state_reg   <= S_MP;
                    end
                end
                S_MP:
                begin
                    acc_reg <= mul_sum;
                    if (cnt_last)
                    begin
                        mul_a_reg <= ACC_W'(error_sum_reg);
                        mul_b_reg <= gain_i_reg;
                        cnt_reg   <= CNT_W'(MULB_W - 1);
                        state_reg <= S_MI;
                    end
                end
                S_MI:
                begin
                    acc_reg <= mul_sum;
                    if (cnt_last)
                    begin
                        mul_a_reg <= ACC_W'(deriv_reg);
                        mul_b_reg <= gain_d_reg;
                        cnt_reg   <= CNT_W'(MULB_W - 1);
                        state_reg <= S_MD;
                    end
                end
                S_MD:
                begin
                    acc_reg <= mul_sum;
                    if (cnt_last)
                        state_reg <= S_SCL;
                end
                S_SCL:
                begin
                    ctrl_reg  <= ctrl_next;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {duty_next, dir_next, ctrl_reg, speed_reg};
                        m_user_reg  <= clr_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // A clear-position request zeroes the stored position.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tuser == OP_CLEAR_POS |=> last_position_reg == '0)
        else $error("stored position not cleared");

    // A counter-clear result carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_user_reg |-> m_data_reg == '0)
        else $error("clear result carries nonzero fields");

    // A new result is only raised from the output state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output state");

    // Forward direction goes with a positive control value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_data_reg[33:32] == DIR_FWD |-> $signed(m_data_reg[31:16]) > 0)
        else $error("direction does not match control sign");

endmodule
